// ----- rtl/nit_lcn_extractor_assert.svh -----
// Assertion macros used by the checker file of the LCN extractor.
`ifndef NIT_LCN_EXTRACTOR_ASSERT_SVH
`define NIT_LCN_EXTRACTOR_ASSERT_SVH
// Implication checked at every rising clock edge, idle during reset.
`define NLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked at every rising clock edge.
`define NLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/nle_pkg.sv -----
// Shared types and constants of the NIT logical channel number extractor.
package nle_pkg;
  localparam int TableDepthDefault = 256;
  localparam logic [7:0] TagResetValue = 8'h83;
  localparam logic [7:0] TableIdActual = 8'h40;
  localparam logic [7:0] TableIdOther = 8'h41;
  localparam logic [13:0] UndefLcn = 14'd10000;
  localparam logic [9:0] MaxLcn = 10'd1000;
  localparam logic [12:0] PosMax = 13'd8191;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEADER, PH_NETSKIP, PH_TSLL_HI, PH_TSLL_LO,
    PH_TSHDR, PH_DTAG, PH_DLEN, PH_DBODY
  } phase_t;

  typedef enum logic [2:0] {
    ST_READY, ST_SEARCH, ST_INSERT, ST_RESULT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic parse_byte;   // apply the held byte to the parser
    logic search_start; // clear the search index
    logic search_step;  // compare one table entry
    logic insert;       // append the held record
    logic result_load;  // load the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_record;  // the parsed byte completes a record
    logic search_done;  // search finished (hit or end of table)
    logic hit;
  } ctl_sts_t;
endpackage

// ----- rtl/nle_ctrl.sv -----
// Controller state machine: sequences parsing, table search and insert.
module nle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               in_func,
  input  logic               out_busy,
  input  logic               out_take,
  input  nle_pkg::ctl_sts_t  sts,
  output logic               accept_ok,
  output nle_pkg::ctl_cmd_t  cmd
);
  nle_pkg::ctl_state_t state, state_next;
  logic is_lookup, is_lookup_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nle_pkg::ST_READY;
      is_lookup <= 1'b0;
    end else begin
      state <= state_next;
      is_lookup <= is_lookup_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    is_lookup_next = is_lookup;
    case (state)
      nle_pkg::ST_READY: begin
        if (in_fire) begin
          is_lookup_next = in_func;
          state_next = nle_pkg::ST_SEARCH;
          if (!in_func) state_next = nle_pkg::ST_INSERT;
        end
      end
      nle_pkg::ST_INSERT: begin
        // The byte is parsed here; a finished record goes on to the search.
        if (sts.need_record) state_next = nle_pkg::ST_SEARCH;
        else state_next = nle_pkg::ST_READY;
      end
      nle_pkg::ST_SEARCH: begin
        if (sts.search_done) begin
          if (is_lookup) state_next = nle_pkg::ST_RESULT;
          else state_next = nle_pkg::ST_READY;
        end
      end
      nle_pkg::ST_RESULT: begin
        if (!out_busy || out_take) state_next = nle_pkg::ST_READY;
      end
      default: state_next = nle_pkg::ST_READY;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    accept_ok = 1'b0;
    case (state)
      nle_pkg::ST_READY: begin
        accept_ok = 1'b1;
        cmd.search_start = 1'b1;
      end
      nle_pkg::ST_INSERT: cmd.parse_byte = 1'b1;
      nle_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
        cmd.insert = sts.search_done && !sts.hit && !is_lookup;
      end
      nle_pkg::ST_RESULT: cmd.result_load = !out_busy || out_take;
      default: cmd = '0;
    endcase
  end
endmodule

// ----- rtl/nle_dpath.sv -----
// Datapath: section parser registers, channel table memory and search.
module nle_dpath #(
  parameter int TABLE_DEPTH = nle_pkg::TableDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               in_func,
  input  logic               in_start,
  input  logic [7:0]         in_byte,
  input  logic [15:0]        q_onid,
  input  logic [15:0]        q_tsid,
  input  logic [15:0]        q_sid,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  nle_pkg::ctl_cmd_t  cmd,
  output nle_pkg::ctl_sts_t  sts,
  output logic               res_found,
  output logic [13:0]        res_lcn
);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Table memory: onid, tsid, sid, lcn.
  logic [61:0] mem [TABLE_DEPTH];
  logic [61:0] rd_data;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] sidx;
  logic rd_valid;

  logic [7:0] tag_reg;
  logic start_h;
  logic [7:0] byte_h;
  logic [15:0] k_onid, k_tsid, k_sid;
  logic [13:0] k_lcn;

  nle_pkg::phase_t phase;
  logic [12:0] pos;
  logic [11:0] sec_len;
  logic [13:0] outer_rem, inner_rem;
  logic [8:0] desc_rem;
  logic [7:0] cur_tag;
  logic [15:0] cur_tsid, cur_onid;
  logic [31:0] rec;
  logic lcn_act;
  logic [1:0] tail;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) tag_reg <= nle_pkg::TagResetValue;
    else if (cfg_we) tag_reg <= cfg_data;
  end

  // Capture the accepted item; while a byte is parsed, load the record key and LCN.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      start_h <= in_start;
      byte_h <= in_byte;
      if (in_func) begin
        k_onid <= q_onid;
        k_tsid <= q_tsid;
        k_sid <= q_sid;
      end
    end else if (cmd.parse_byte) begin
      k_onid <= cur_onid;
      k_tsid <= cur_tsid;
      k_sid <= rec[23:8];
      if ({rec[1:0], byte_h} == 10'd0 || {rec[1:0], byte_h} >= nle_pkg::MaxLcn)
        k_lcn <= nle_pkg::UndefLcn;
      else k_lcn <= {4'd0, rec[1:0], byte_h};
    end
  end

  // Parser next-state logic for one byte.
  logic [31:0] rec_n;
  logic rec_done;
  always_comb begin
    rec_n = {rec[23:0], byte_h};
    rec_done = 1'b0;
    if (phase == nle_pkg::PH_DBODY && lcn_act && desc_rem > {7'd0, tail}
        && ((desc_rem - {7'd0, tail}) & 9'd3) == 9'd1)
      rec_done = 1'b1;
  end

  // Loop bound helpers.
  function automatic nle_pkg::phase_t outer_top(input logic [13:0] orem,
                                                input logic [12:0] p,
                                                input logic [11:0] sl);
    if (orem != 14'd0 && ({1'b0, p} + 14'd2) <= {2'd0, sl})
      return nle_pkg::PH_TSHDR;
    return nle_pkg::PH_IDLE;
  endfunction

  logic [12:0] pos_inc;
  logic [13:0] dlen2;
  logic [13:0] irem_d, orem_d;
  logic [12:0] idx;
  always_comb begin
    idx = pos;
    pos_inc = (pos < nle_pkg::PosMax) ? pos + 13'd1 : pos;
    dlen2 = {6'd0, byte_h} + 14'd2;
    irem_d = (inner_rem > dlen2) ? inner_rem - dlen2 : 14'd0;
    orem_d = (outer_rem > dlen2) ? outer_rem - dlen2 : 14'd0;
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= nle_pkg::PH_IDLE;
      pos <= '0;
      sec_len <= '0;
      outer_rem <= '0;
      inner_rem <= '0;
      desc_rem <= '0;
      cur_tag <= '0;
      cur_tsid <= '0;
      cur_onid <= '0;
      rec <= '0;
      lcn_act <= 1'b0;
      tail <= '0;
    end else if (cmd.parse_byte) begin
      if (start_h) begin
        pos <= 13'd1;
        sec_len <= '0;
        outer_rem <= '0;
        inner_rem <= '0;
        desc_rem <= '0;
        lcn_act <= 1'b0;
        tail <= '0;
        phase <= (byte_h == nle_pkg::TableIdActual || byte_h == nle_pkg::TableIdOther)
                 ? nle_pkg::PH_HEADER : nle_pkg::PH_IDLE;
      end else if (phase != nle_pkg::PH_IDLE) begin
        pos <= pos_inc;
        case (phase)
          nle_pkg::PH_HEADER: begin
            if (idx == 13'd1) sec_len <= {byte_h[3:0], 8'd0};
            else if (idx == 13'd2) sec_len <= {sec_len[11:8], byte_h};
            else if (idx == 13'd8) outer_rem <= {2'd0, byte_h[3:0], 8'd0};
            else if (idx == 13'd9) begin
              outer_rem <= {outer_rem[13:8], byte_h};
              if ({outer_rem[13:8], byte_h} == 14'd0)
                phase <= (pos_inc > {1'b0, sec_len}) ? nle_pkg::PH_IDLE
                                                     : nle_pkg::PH_TSLL_HI;
              else phase <= nle_pkg::PH_NETSKIP;
            end
          end
          nle_pkg::PH_NETSKIP: begin
            outer_rem <= (outer_rem != 0) ? outer_rem - 14'd1 : 14'd0;
            if (outer_rem <= 14'd1)
              phase <= (pos_inc > {1'b0, sec_len}) ? nle_pkg::PH_IDLE
                                                   : nle_pkg::PH_TSLL_HI;
          end
          nle_pkg::PH_TSLL_HI: begin
            outer_rem <= {2'd0, byte_h[3:0], 8'd0};
            phase <= nle_pkg::PH_TSLL_LO;
          end
          nle_pkg::PH_TSLL_LO: begin
            outer_rem <= {outer_rem[13:8], byte_h};
            phase <= outer_top({outer_rem[13:8], byte_h}, pos_inc, sec_len);
            desc_rem <= 9'd6;
          end
          nle_pkg::PH_TSHDR: begin
            case (desc_rem)
              9'd6: cur_tsid <= {byte_h, 8'd0};
              9'd5: cur_tsid <= {cur_tsid[15:8], byte_h};
              9'd4: cur_onid <= {byte_h, 8'd0};
              9'd3: cur_onid <= {cur_onid[15:8], byte_h};
              9'd2: inner_rem <= {2'd0, byte_h[3:0], 8'd0};
              default: inner_rem <= {inner_rem[13:8], byte_h};
            endcase
            desc_rem <= (desc_rem != 0) ? desc_rem - 9'd1 : 9'd0;
            if (desc_rem <= 9'd1) begin
              outer_rem <= (outer_rem > 14'd6) ? outer_rem - 14'd6 : 14'd0;
              if ({inner_rem[13:8], byte_h} != 14'd0)
                phase <= (({1'b0, pos_inc} + 14'd2) > {2'd0, sec_len})
                         ? nle_pkg::PH_IDLE : nle_pkg::PH_DTAG;
              else begin
                phase <= outer_top((outer_rem > 14'd6) ? outer_rem - 14'd6 : 14'd0,
                                   pos_inc, sec_len);
                desc_rem <= 9'd6;
              end
            end
          end
          nle_pkg::PH_DTAG: begin
            cur_tag <= byte_h;
            phase <= nle_pkg::PH_DLEN;
          end
          nle_pkg::PH_DLEN: begin
            inner_rem <= irem_d;
            outer_rem <= orem_d;
            desc_rem <= {1'b0, byte_h};
            lcn_act <= (cur_tag == tag_reg) && byte_h >= 8'd4;
            tail <= byte_h[1:0];
            if (byte_h == 8'd0) begin
              if (irem_d != 0)
                phase <= (({1'b0, pos_inc} + 14'd2) > {2'd0, sec_len})
                         ? nle_pkg::PH_IDLE : nle_pkg::PH_DTAG;
              else begin
                phase <= outer_top(orem_d, pos_inc, sec_len);
                desc_rem <= 9'd6;
              end
            end else phase <= nle_pkg::PH_DBODY;
          end
          nle_pkg::PH_DBODY: begin
            if (lcn_act && desc_rem > {7'd0, tail}) rec <= rec_n;
            desc_rem <= (desc_rem != 0) ? desc_rem - 9'd1 : 9'd0;
            if (desc_rem <= 9'd1) begin
              if (inner_rem != 0)
                phase <= (({1'b0, pos_inc} + 14'd2) > {2'd0, sec_len})
                         ? nle_pkg::PH_IDLE : nle_pkg::PH_DTAG;
              else begin
                phase <= outer_top(outer_rem, pos_inc, sec_len);
                desc_rem <= 9'd6;
              end
            end
          end
          default: phase <= nle_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Record status: only records with all ids nonzero ever go to search.
  assign sts.need_record = !start_h && rec_done
                           && cur_onid != 0 && cur_tsid != 0
                           && rec[23:8] != 16'd0;

  // Sequential search, one entry read per cycle with registered data.
  logic [CW-1:0] rd_idx;
  logic match;
  assign match = rd_valid && rd_data[61:46] == k_onid && rd_data[45:30] == k_tsid
                 && rd_data[29:14] == k_sid;
  assign sts.hit = match;
  assign sts.search_done = match || (!rd_valid && sidx >= entry_count);
  assign rd_idx = sidx;

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      sidx <= '0;
      rd_valid <= 1'b0;
    end else if (cmd.search_step) begin
      if (rd_valid || sidx < entry_count) begin
        rd_valid <= sidx < entry_count;
        if (sidx < entry_count) sidx <= sidx + 1'b1;
      end
    end
    if (sidx < entry_count) rd_data <= mem[rd_idx[IW-1:0]];
  end

  // Table write and fill count.
  always_ff @(posedge clk) begin
    if (rst) entry_count <= '0;
    else if (cmd.insert && entry_count < CW'(TABLE_DEPTH)) begin
      mem[entry_count[IW-1:0]] <= {k_onid, k_tsid, k_sid, k_lcn};
      entry_count <= entry_count + 1'b1;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.search_step && sts.search_done) begin
      res_found <= match;
      res_lcn <= match ? rd_data[13:0] : nle_pkg::UndefLcn;
    end
  end
endmodule

// ----- rtl/nit_lcn_extractor.sv -----
// Top level of the NIT logical channel number extractor.
// Usage:
// - s_axis carries items: a section byte (func 0) or a lookup (func 1).
//   tuser holds func (bit 0) and section_start (bit 1).
// - m_axis returns one item per lookup: found and channel_number.
// - cfg_we/cfg_data write the LCN descriptor tag (reset 0x83).
// Sequencing:
// - A section byte is parsed in the INSERT state; one that completes a channel
//   record then runs a duplicate search of the table, which ends with the
//   insert when no match is found.
// - A lookup runs the sequential table search, one entry per cycle, and
//   then loads the output register.
// - A new item is accepted only after the last one is done.
// Reset clears the parser, the table fill count and the output valid.
// When the receiver stalls, a result waits in the output register; the
// block still accepts and parses until a second result is ready, which it
// holds, accepting nothing, until the register frees.
module nit_lcn_extractor #(
  parameter int TABLE_DEPTH = nle_pkg::TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // data_byte, query_network_id,
                                     // query_transport_id, query_service_id
  input  logic [1:0]  s_axis_tuser,  // func, section_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // found, channel_number, zero fill
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);
  nle_pkg::ctl_cmd_t cmd;
  nle_pkg::ctl_sts_t sts;
  logic accept_ok, in_fire, out_take;
  logic res_found;
  logic [13:0] res_lcn;

  assign s_axis_tready = accept_ok;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  nle_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_func(s_axis_tuser[0]),
    .out_busy(m_axis_tvalid), .out_take, .sts, .accept_ok, .cmd
  );

  nle_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk, .rst, .in_fire, .in_func(s_axis_tuser[0]), .in_start(s_axis_tuser[1]),
    .in_byte(s_axis_tdata[7:0]), .q_onid(s_axis_tdata[23:8]),
    .q_tsid(s_axis_tdata[39:24]), .q_sid(s_axis_tdata[55:40]),
    .cfg_we, .cfg_data, .cmd, .sts, .res_found, .res_lcn
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.result_load) m_axis_tvalid <= 1'b1;
    else if (out_take) m_axis_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) m_axis_tdata <= {1'b0, res_lcn, res_found};
  end
endmodule

// ----- rtl/nle_checker.sv -----
// Port-level checker for the NIT LCN extractor, bound to the top level.
`include "nit_lcn_extractor_assert.svh"
module nle_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  `NLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output changed while stalled")
  `NLE_ASSERT_IMP(a_notfound_undef, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[14:1] == 14'd10000, "miss without undefined number")
  `NLE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted two items back to back")
  `NLE_ASSERT_IMP(a_pad_zero, m_axis_tvalid, !m_axis_tdata[15], "padding bit set")
endmodule

bind nit_lcn_extractor nle_checker u_nle_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
